// ===== rtl/ilir_pkg.sv =====
`default_nettype none

package ilir_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;

  // Port widths of the command and result words
  localparam int POS_W  = 5;
  localparam int WORD_W = 32;
  localparam int ECNT_W = 5;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // Shift control broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [CMP_W-1:0] pos;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/ilir_cell.sv =====
`default_nettype none

module ilir_cell
  import ilir_pkg::*;
(
  input  wire logic             clk_i,
  input  cell_ctl_t             ctl_i,
  input  wire logic [IDX_W-1:0] idx_i,
  input  data_t                 prev_i,
  input  data_t                 next_i,
  input  data_t                 word_i,
  output data_t                 data_o,
  output data_t                 tap_o
);

  data_t            data_d, data_q;
  logic [CMP_W-1:0] idx;

  assign idx = CMP_W'(idx_i);

  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      // move back behind the insertion point, take the new word at it
      if (idx > ctl_i.pos) begin
        data_d = prev_i;
      end else if (idx == ctl_i.pos) begin
        data_d = word_i;
      end
    end else if (ctl_i.rem) begin
      if (idx >= ctl_i.pos) begin
        data_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign tap_o  = (idx == ctl_i.pos) ? data_q : '0;

endmodule

`default_nettype wire

// ===== rtl/ilir_ctrl.sv =====
`default_nettype none

module ilir_ctrl
  import ilir_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire logic [1:0]       command_i,
  input  wire logic [POS_W-1:0] position_i,
  output cell_ctl_t             ctl_o,
  output logic [CNT_W-1:0]      count_o,
  output status_e               status_o,
  output logic                  rd_ok_o
);

  logic [CNT_W-1:0] count_d, count_q;
  logic [CMP_W-1:0] pos, cnt;

  assign pos = CMP_W'(position_i);
  assign cnt = CMP_W'(count_q);

  always_comb begin
    count_d   = count_q;
    status_o  = ST_OK;
    rd_ok_o   = 1'b0;
    ctl_o.ins = 1'b0;
    ctl_o.rem = 1'b0;
    ctl_o.pos = pos;
    unique case (cmd_e'(command_i))
      CMD_INSERT: begin
        // index check ranks ahead of the full check
        if (pos > cnt) begin
          status_o = ST_INVALID;
        end else if (cnt >= CMP_W'(CAPACITY)) begin
          status_o = ST_FULL;
        end else begin
          ctl_o.ins = start;
          count_d   = count_q + CNT_W'(1);
        end
      end
      CMD_REMOVE, CMD_READ: begin
        if (count_q == '0) begin
          status_o = ST_EMPTY;
        end else if (pos >= cnt) begin
          status_o = ST_INVALID;
        end else begin
          rd_ok_o = 1'b1;
          if (cmd_e'(command_i) == CMD_REMOVE) begin
            ctl_o.rem = start;
            count_d   = count_q - CNT_W'(1);
          end
        end
      end
      CMD_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    if (!start) begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_d;

endmodule

`default_nettype wire

// ===== rtl/indexed_list_insert_remove.sv =====
`default_nettype none

// Positional list of up to 16 words held in a row of cells, one word per
// cell. A command is taken in every cycle (busy stays low): all cells shift
// in parallel in the cycle the command is taken, so insert and remove take
// no longer than read and clear. The result word, the entry count
// after the command and the status appear on the result ports, marked by
// result_valid_o, in the cycle after start, for one cycle only; the
// receiver cannot stall and must take each word as it comes. Words are
// kept only below the entry count; a refused insert (bad index or full
// list) and a failed read or remove change nothing.
module indexed_list_insert_remove
  import ilir_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        command_i,
  input  wire logic [POS_W-1:0]  position_i,
  input  wire logic [WORD_W-1:0] word_in_i,
  output logic                   result_valid_o,
  output logic [WORD_W-1:0]      word_out_o,
  output logic [ECNT_W-1:0]      entry_count_o,
  output logic [1:0]             status_o
);

  cell_ctl_t        ctl;
  logic [CNT_W-1:0] count;
  status_e          status;
  logic             rd_ok;
  data_t            cell_data [CAPACITY];
  data_t            cell_tap  [CAPACITY];
  data_t            rd_word;
  data_t            word_in;

  logic              valid_q;
  logic [WORD_W-1:0] word_q;
  logic [ECNT_W-1:0] count_q;
  status_e           status_q;

  assign word_in = DATA_W'(word_in_i);

  ilir_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start,
    .command_i,
    .position_i,
    .ctl_o    (ctl),
    .count_o  (count),
    .status_o (status),
    .rd_ok_o  (rd_ok)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    data_t prev, next;
    if (g == 0) begin : g_first
      assign prev = '0;
    end else begin : g_mid
      assign prev = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next = '0;
    end else begin : g_tail
      assign next = cell_data[g+1];
    end
    ilir_cell u_cell (
      .clk_i,
      .ctl_i  (ctl),
      .idx_i  (IDX_W'(g)),
      .prev_i (prev),
      .next_i (next),
      .word_i (word_in),
      .data_o (cell_data[g]),
      .tap_o  (cell_tap[g])
    );
  end

  // only the addressed cell drives its tap
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_tap[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      word_q   <= rd_ok ? WORD_W'(rd_word) : '0;
      count_q  <= ECNT_W'(count);
      status_q <= status;
    end
  end

  assign busy           = 1'b0;
  assign result_valid_o = valid_q;
  assign word_out_o     = word_q;
  assign entry_count_o  = count_q;
  assign status_o       = status_q;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_ctrl.count_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> result_valid_o)
    else $error("command gave no result word");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start |=> !result_valid_o)
    else $error("result word without a command");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == ST_FULL) |-> entry_count_o == ECNT_W'(CAPACITY))
    else $error("full status with room left");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == ST_EMPTY) |-> (entry_count_o == '0 && word_out_o == '0))
    else $error("empty status on a non-empty list");
`endif

endmodule

`default_nettype wire

// ===== test/tb_indexed_list_insert_remove.sv =====
`default_nettype none

module tb_indexed_list_insert_remove;
  import ilir_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic [ECNT_W-1:0] cnt;
    status_e           st;
  } list_result_t;

  // Shadow copy of the list plus the queue of outcomes still to come back
  class list_scoreboard;
    data_t        slots[CAPACITY];
    int unsigned  fill;
    list_result_t awaited[$];
    int           errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endtask

    function void note_command(cmd_e cmd, logic [POS_W-1:0] pos, logic [WORD_W-1:0] w);
      list_result_t r;
      int unsigned  p;
      p      = pos;
      r.word = '0;
      r.st   = ST_OK;
      case (cmd)
        CMD_INSERT: begin
          // an index past the end wins over a full list
          if (p > fill) begin
            r.st = ST_INVALID;
          end else if (fill == CAPACITY) begin
            r.st = ST_FULL;
          end else begin
            for (int i = fill; i > p; i--) slots[i] = slots[i-1];
            slots[p] = data_t'(w);
            fill++;
          end
        end
        CMD_REMOVE, CMD_READ: begin
          if (fill == 0) begin
            r.st = ST_EMPTY;
          end else if (p >= fill) begin
            r.st = ST_INVALID;
          end else begin
            r.word = WORD_W'(slots[p]);
            if (cmd == CMD_REMOVE) begin
              for (int i = p; i + 1 < fill; i++) slots[i] = slots[i+1];
              fill--;
            end
          end
        end
        default: fill = 0;
      endcase
      r.cnt = ECNT_W'(fill);
      awaited.push_back(r);
    endfunction

    task check_result(logic [WORD_W-1:0] word, logic [ECNT_W-1:0] cnt, logic [1:0] st);
      list_result_t exp;
      if (awaited.size() == 0) begin
        report("result word with no command waiting");
        return;
      end
      exp = awaited.pop_front();
      if (word !== exp.word) begin
        report($sformatf("word_out %h, expected %h", word, exp.word));
      end
      if (cnt !== exp.cnt) begin
        report($sformatf("entry_count %0d, expected %0d", cnt, exp.cnt));
      end
      if (st !== exp.st) begin
        report($sformatf("status %0d, expected %s", st, exp.st.name()));
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        command_i = CMD_READ;
  logic [POS_W-1:0]  position_i = '0;
  logic [WORD_W-1:0] word_in_i = '0;
  logic              result_valid_o;
  logic [WORD_W-1:0] word_out_o;
  logic [ECNT_W-1:0] entry_count_o;
  logic [1:0]        status_o;

  list_scoreboard sb = new();
  int unsigned    words_sent;

  indexed_list_insert_remove uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .position_i     (position_i),
    .word_in_i      (word_in_i),
    .result_valid_o (result_valid_o),
    .word_out_o     (word_out_o),
    .entry_count_o  (entry_count_o),
    .status_o       (status_o)
  );

  always #6 clk_i = ~clk_i;

  // Check the returning word before noting a new command on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(word_out_o, entry_count_o, status_o);
      if (start && !busy) sb.note_command(cmd_e'(command_i), position_i, word_in_i);
    end
  end

  task automatic issue(cmd_e c, int unsigned p, logic [WORD_W-1:0] w);
    start      <= 1'b1;
    command_i  <= c;
    position_i <= POS_W'(p);
    word_in_i  <= w;
    do @(posedge clk_i); while (busy);
    words_sent++;
  endtask

  // Hold start low and scribble on the fields while idle
  task automatic idle(int unsigned n);
    start <= 1'b0;
    repeat (n) begin
      command_i  <= 2'($urandom);
      position_i <= POS_W'($urandom);
      word_in_i  <= $urandom;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_directed();
    issue(CMD_READ, 0, 32'h1234_5678);
    issue(CMD_REMOVE, 0, '1);
    issue(CMD_INSERT, 1, 32'hDEAD_BEEF);
    issue(CMD_INSERT, 0, '1);
    issue(CMD_INSERT, 1, '0);
    issue(CMD_INSERT, 0, 32'hA5A5_A5A5);
    issue(CMD_READ, 2, '1);
    issue(CMD_READ, 3, '0);
    issue(CMD_REMOVE, 1, '0);
    // fill to capacity from two entries, at random spots
    for (int k = 2; k < CAPACITY; k++) issue(CMD_INSERT, $urandom_range(0, k), $urandom);
    issue(CMD_INSERT, CAPACITY, 32'h5A5A_5A5A);
    issue(CMD_INSERT, CAPACITY + 1, 32'h5A5A_5A5A);
    issue(CMD_READ, CAPACITY - 1, '0);
    issue(CMD_READ, CAPACITY, '0);
    issue(CMD_REMOVE, 31, '1);
    issue(CMD_REMOVE, CAPACITY - 1, '0);
    issue(CMD_REMOVE, 0, '0);
    issue(CMD_CLEAR, 31, '1);
    issue(CMD_READ, 0, '0);
    drain();
  endtask

  task automatic run_random(int unsigned total);
    int unsigned target;
    int unsigned burst;
    int unsigned roll;
    int unsigned p;
    int unsigned cnt;
    bit          growing;
    cmd_e        c;
    target  = words_sent + total;
    growing = 1'b1;
    while (words_sent < target) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && words_sent < target; b++) begin
        cnt = sb.fill;
        if (cnt >= CAPACITY) growing = 1'b0;
        if (cnt == 0) growing = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll == 99) c = CMD_CLEAR;
        else if (roll < (growing ? 60 : 25)) c = CMD_INSERT;
        else if (roll < (growing ? 75 : 65)) c = CMD_REMOVE;
        else c = CMD_READ;
        // mostly in-range positions, the rest anywhere in the field
        if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 31);
        else if (c == CMD_INSERT) p = $urandom_range(0, cnt);
        else p = (cnt > 0) ? $urandom_range(0, cnt - 1) : 0;
        issue(c, p, pick_word());
      end
      roll = $urandom_range(0, 19);
      if (roll == 0) drain();
      else if (roll < 12) idle($urandom_range(1, 8));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random(1870);
    drain();
    repeat (4) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("[indexed_list_insert_remove] OK");
    end else begin
      $display("[indexed_list_insert_remove] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[indexed_list_insert_remove] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/ilir_pkg.sv
rtl/ilir_cell.sv
rtl/ilir_ctrl.sv
rtl/indexed_list_insert_remove.sv
test/tb_indexed_list_insert_remove.sv
